>>> sv/lgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the toroidal life generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int unsigned GRID_WIDTH_DEF  = 64;
  localparam int unsigned GRID_HEIGHT_DEF = 64;

  localparam int unsigned ROW_IDX_W = 6;
  localparam int unsigned ROW_W     = 64;

  // neighbor counts of the rule
  localparam logic [3:0] SURVIVE_CNT = 4'd2;
  localparam logic [3:0] BIRTH_CNT   = 4'd3;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_READ    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_GEN
  } state_e;

endpackage : lgs_pkg
`default_nettype wire

>>> sv/life_generation_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_step
// Toroidal life grid held in a row memory: write a row, read a row, or advance
// one generation by sweeping all rows through a three-row window.
// ----------------------------------------------------------------------------
// write and advance answer in the cycle after acceptance, reads via ST_READ
// throughput: write one transaction per cycle unless the output stalls; a read
//   stalls the input through ST_READ; an advance holds it for its sweep, one
//   memory row read and written per cycle plus a wrap-around fill and drain
// reset: all rows read as dead through per-row valid bits, no clearing pass
// ----------------------------------------------------------------------------
module life_generation_step #(
  parameter int unsigned GRID_WIDTH  = lgs_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = lgs_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [lgs_pkg::ROW_IDX_W-1:0] row_index_i,
  input  wire logic [lgs_pkg::ROW_W-1:0]     row_cells_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [lgs_pkg::ROW_W-1:0]     row_out_o
);
  import lgs_pkg::*;

  localparam int unsigned AW = $clog2(GRID_HEIGHT);
  localparam int unsigned CW = $clog2(GRID_HEIGHT + 3);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q;
  logic [ROW_W-1:0] out_data_q;
  logic          rd_oob_q;
  logic [GRID_WIDTH-1:0] top_q, mid_q, row0_q;

  logic in_acc;
  logic [8:0] ri_ext;
  logic       ri_ok;
  logic [CW-1:0] cnt_m1, cnt_m3;

  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [GRID_WIDTH-1:0] wdata, rdata, bot, nxt;
  logic                  out_load;
  logic [ROW_W-1:0]      out_load_data;
  logic                  win_shift, last_row;

  assign in_acc = in_valid_i && !in_stall_o;
  assign ri_ext = 9'(row_index_i);
  assign ri_ok  = ri_ext < 9'(GRID_HEIGHT);
  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_m3 = cnt_q - CW'(3);
  assign last_row  = (cnt_q == CW'(GRID_HEIGHT + 2));
  assign win_shift = (cnt_q != '0) && (cnt_q <= CW'(GRID_HEIGHT + 1));
  assign bot = last_row ? row0_q : rdata;

  lgs_mem #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .ADDR_W      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lgs_rule #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_rule (
    .up_i   (top_q),
    .mid_i  (mid_q),
    .dn_i   (bot),
    .next_o (nxt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode_i == MODE_READ)) begin
          state_d = ST_READ;
        end else if (in_acc && (mode_i == MODE_ADVANCE)) begin
          state_d = ST_GEN;
          cnt_d   = '0;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_GEN: begin
        if (last_row) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;
    out_load      = 1'b0;
    out_load_data = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            MODE_WRITE: begin
              we       = ri_ok;
              waddr    = ri_ext[AW-1:0];
              wdata    = row_cells_i[GRID_WIDTH-1:0];
              out_load = 1'b1;
            end
            MODE_ADVANCE: begin
              out_load = 1'b1;
            end
            MODE_READ: begin
              re    = ri_ok;
              raddr = ri_ext[AW-1:0];
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        if (!rd_oob_q) begin
          out_load_data = ROW_W'(rdata);
        end
      end
      ST_GEN: begin
        if (cnt_q <= CW'(GRID_HEIGHT)) begin
          re    = 1'b1;
          raddr = (cnt_q == '0) ? AW'(GRID_HEIGHT - 1) : cnt_m1[AW-1:0];
        end
        if (last_row) begin
          we    = 1'b1;
          waddr = AW'(GRID_HEIGHT - 1);
          wdata = nxt;
        end else if (cnt_q >= CW'(3)) begin
          we    = 1'b1;
          waddr = cnt_m3[AW-1:0];
          wdata = nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rd_oob_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        rd_oob_q <= !ri_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_load_data;
    end
    if ((state_q == ST_GEN) && win_shift) begin
      top_q <= mid_q;
      mid_q <= rdata;
    end
    if ((state_q == ST_GEN) && (cnt_q == CW'(2))) begin
      row0_q <= rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_out_o   = out_data_q;

endmodule : life_generation_step
`default_nettype wire

>>> sv/lgs_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_mem
// Row memory of the cell grid with one write and one registered read port.
// Per-row valid bits make never-written rows read as all dead.
// ----------------------------------------------------------------------------
module lgs_mem #(
  parameter int unsigned GRID_WIDTH  = 64,
  parameter int unsigned GRID_HEIGHT = 64,
  parameter int unsigned ADDR_W      = $clog2(GRID_HEIGHT)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire logic [ADDR_W-1:0]     waddr_i,
  input  wire logic [GRID_WIDTH-1:0] wdata_i,
  input  wire logic                  re_i,
  input  wire logic [ADDR_W-1:0]     raddr_i,
  output logic      [GRID_WIDTH-1:0] rdata_o
);

  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] rd_q;
  logic [GRID_HEIGHT-1:0] valid_q;
  logic                  rdv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rdv_q   <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rdv_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdv_q ? rd_q : '0;

endmodule : lgs_mem
`default_nettype wire

>>> sv/lgs_rule.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_rule
// Next-generation row from three old rows with wrap-around columns.
// ----------------------------------------------------------------------------
module lgs_rule #(
  parameter int unsigned GRID_WIDTH = 64
) (
  input  wire logic [GRID_WIDTH-1:0] up_i,
  input  wire logic [GRID_WIDTH-1:0] mid_i,
  input  wire logic [GRID_WIDTH-1:0] dn_i,
  output logic      [GRID_WIDTH-1:0] next_o
);
  import lgs_pkg::*;

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    localparam int unsigned LF = (c + GRID_WIDTH - 1) % GRID_WIDTH;
    localparam int unsigned RT = (c + 1) % GRID_WIDTH;
    logic [3:0] cnt;

    assign cnt = 4'(up_i[LF]) + 4'(up_i[c]) + 4'(up_i[RT])
               + 4'(mid_i[LF]) + 4'(mid_i[RT])
               + 4'(dn_i[LF]) + 4'(dn_i[c]) + 4'(dn_i[RT]);

    assign next_o[c] = (cnt == BIRTH_CNT) || (mid_i[c] && (cnt == SURVIVE_CNT));
  end

endmodule : lgs_rule
`default_nettype wire
